>>> hw/rtl/npt_pkg.sv
`default_nettype none
package npt_pkg;

  localparam int HOST_ENTRIES = 16;
  localparam int IDX_W = (HOST_ENTRIES > 1) ? $clog2(HOST_ENTRIES) : 1;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PUBLIC_ADDR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INSIDE_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ICMP_REDIRECT = 2'd2;

  localparam logic [31:0] PUBLIC_ADDR_RST   = 32'hC0A8_0065;
  localparam logic [31:0] INSIDE_BASE_RST   = 32'hAC11_0000;
  localparam logic [31:0] ICMP_REDIRECT_RST = 32'hDA07_2B08;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_L4_SEG    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_L4_SRC_HI = 4'd1;
  localparam logic [STEP_W-1:0] STEP_L4_SRC_LO = 4'd2;
  localparam logic [STEP_W-1:0] STEP_L4_DST_HI = 4'd3;
  localparam logic [STEP_W-1:0] STEP_L4_DST_LO = 4'd4;
  localparam logic [STEP_W-1:0] STEP_L4_PROTO  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_L4_LEN    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_IP_REST   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_IP_SRC_HI = 4'd8;
  localparam logic [STEP_W-1:0] STEP_IP_SRC_LO = 4'd9;
  localparam logic [STEP_W-1:0] STEP_IP_DST_HI = 4'd10;
  localparam logic [STEP_W-1:0] STEP_IP_DST_LO = 4'd11;

  typedef struct packed {
    logic             we_tcp;
    logic             we_udp;
    logic             we_icmp;
    logic [IDX_W-1:0] idx;
    logic [15:0]      port;
    logic [15:0]      echo_id;
    logic [15:0]      echo_seq;
  } tbl_wr_t;

  typedef struct packed {
    logic [15:0] tcp_port;
    logic [15:0] udp_port;
    logic [15:0] echo_id;
    logic [15:0] echo_seq;
  } tbl_rd_t;

  typedef struct packed {
    logic        load;
    logic        add;
    logic [15:0] term;
  } csum_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

endpackage
`default_nettype wire

>>> hw/rtl/npt_in_if.sv
`default_nettype none
interface npt_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic        on_wan_port;
  logic [7:0]  protocol;
  logic [31:0] src_addr;
  logic [31:0] dst_addr;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [15:0] echo_id;
  logic [15:0] echo_seq;
  logic [15:0] l4_length;
  logic [15:0] l4_sum;
  logic [15:0] ip_rest_sum;

  modport source (
    output valid, func, on_wan_port, protocol, src_addr, dst_addr, src_port, dst_port,
           echo_id, echo_seq, l4_length, l4_sum, ip_rest_sum,
    input  ready
  );
  modport sink (
    input  valid, func, on_wan_port, protocol, src_addr, dst_addr, src_port, dst_port,
           echo_id, echo_seq, l4_length, l4_sum, ip_rest_sum,
    output ready
  );
endinterface
`default_nettype wire

>>> hw/rtl/npt_out_if.sv
`default_nettype none
interface npt_out_if;
  logic        valid;
  logic        ready;
  logic        rewritten;
  logic [3:0]  entry_index;
  logic [31:0] new_src_addr;
  logic [31:0] new_dst_addr;
  logic [15:0] ip_checksum;
  logic [15:0] l4_checksum;
  logic        l4_checksum_valid;
  logic        reroute;

  modport source (
    output valid, rewritten, entry_index, new_src_addr, new_dst_addr, ip_checksum,
           l4_checksum, l4_checksum_valid, reroute,
    input  ready
  );
  modport sink (
    input  valid, rewritten, entry_index, new_src_addr, new_dst_addr, ip_checksum,
           l4_checksum, l4_checksum_valid, reroute,
    output ready
  );
endinterface
`default_nettype wire

>>> hw/rtl/npt_tables.sv
`default_nettype none
module npt_tables (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire npt_pkg::tbl_wr_t         wr,
  input  wire logic [npt_pkg::IDX_W-1:0] rd_idx,
  output npt_pkg::tbl_rd_t              rd
);

  logic [15:0] tcp_r  [npt_pkg::HOST_ENTRIES];
  logic [15:0] udp_r  [npt_pkg::HOST_ENTRIES];
  logic [15:0] id_r   [npt_pkg::HOST_ENTRIES];
  logic [15:0] seq_r  [npt_pkg::HOST_ENTRIES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < npt_pkg::HOST_ENTRIES; i++) begin
        tcp_r[i] <= 16'd0;
        udp_r[i] <= 16'd0;
        id_r[i]  <= 16'd0;
        seq_r[i] <= 16'd0;
      end
    end else begin
      if (wr.we_tcp) begin
        tcp_r[wr.idx] <= wr.port;
      end
      if (wr.we_udp) begin
        udp_r[wr.idx] <= wr.port;
      end
      if (wr.we_icmp) begin
        id_r[wr.idx]  <= wr.echo_id;
        seq_r[wr.idx] <= wr.echo_seq;
      end
    end
  end

  assign rd.tcp_port = tcp_r[rd_idx];
  assign rd.udp_port = udp_r[rd_idx];
  assign rd.echo_id  = id_r[rd_idx];
  assign rd.echo_seq = seq_r[rd_idx];

endmodule
`default_nettype wire

>>> hw/rtl/npt_csum.sv
`default_nettype none
module npt_csum (
  input  wire logic               clk,
  input  wire npt_pkg::csum_ctl_t ctl,
  output logic [15:0]             sum
);

  logic [15:0] acc_r;
  logic [15:0] acc_nxt;
  logic [16:0] raw;

  always_comb begin
    raw     = {1'b0, acc_r} + {1'b0, ctl.term};
    acc_nxt = acc_r;
    if (ctl.load) begin
      acc_nxt = ctl.term;
    end else if (ctl.add) begin
      acc_nxt = raw[15:0] + {15'd0, raw[16]};
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign sum = acc_r;

endmodule
`default_nettype wire

>>> hw/rtl/nat_port_table_rewriter.sv
`default_nettype none
// Source NAT with a fixed table of inside hosts. One request is taken while the block is idle;
// unless it is off the WAN port, or has func set and another destination than the public address,
// it walks the host table one entry per cycle, stopping at the first match or at the last entry,
// then runs the header sums through one shared 16-bit ones-complement adder, one term a cycle:
// L4 pseudo-header and segment terms, then IP terms, for TCP/UDP; IP terms only for ICMP; none
// when nothing matches. The result sits in an output register until taken. Configuration writes
// land on the next clock edge and must be made while no request is in flight.
module nat_port_table_rewriter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  npt_in_if.sink                                 in_chan,
  npt_out_if.source                              out_chan,
  input  wire logic                              cfg_we,
  input  wire logic [npt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [31:0]                       cfg_data
);

  npt_pkg::state_t    state_r, state_nxt;
  npt_pkg::tbl_wr_t   tbl_wr;
  npt_pkg::tbl_rd_t   tbl_rd;
  npt_pkg::csum_ctl_t csum_ctl;
  logic [15:0]        csum;

  logic [31:0] public_addr_r, inside_base_r, icmp_redirect_r;

  logic                      func_r, wan_r;
  logic [7:0]                protocol_r;
  logic [31:0]               src_addr_r;
  logic [15:0]               src_port_r, dst_port_r, echo_id_r, echo_seq_r;
  logic [15:0]               l4_length_r, l4_sum_r, ip_rest_r;
  logic [npt_pkg::IDX_W-1:0] idx_r;
  logic [31:0]               cand_r;
  logic [npt_pkg::STEP_W-1:0] step_r;
  logic                      hit_r;
  logic [31:0]               nsrc_r, ndst_r;
  logic [15:0]               l4_acc_r;

  logic                      out_valid_r;
  logic                      rewritten_r, l4v_r, reroute_r;
  logic [3:0]                entry_r;
  logic [31:0]               out_src_r, out_dst_r;
  logic [15:0]               ipc_r, l4c_r;

  logic accept, is_icmp, is_tcp, is_udp, dir_out, match, last, out_load;
  logic [7:0] l4_proto;

  assign accept   = in_chan.valid && in_chan.ready;
  assign is_icmp  = protocol_r == npt_pkg::PROTO_ICMP;
  assign is_tcp   = protocol_r == npt_pkg::PROTO_TCP;
  assign is_udp   = protocol_r == npt_pkg::PROTO_UDP;
  assign dir_out  = wan_r && !func_r;
  assign l4_proto = is_udp ? npt_pkg::PROTO_UDP : npt_pkg::PROTO_TCP;
  assign last     = idx_r == npt_pkg::IDX_W'(npt_pkg::HOST_ENTRIES - 1);
  assign out_load = (state_r == npt_pkg::ST_FIN) && (!out_valid_r || out_chan.ready);

  always_comb begin
    if (dir_out) begin
      match = src_addr_r == cand_r;
    end else begin
      match = (is_tcp && dst_port_r == tbl_rd.tcp_port) ||
              (is_udp && dst_port_r == tbl_rd.udp_port) ||
              (is_icmp && echo_id_r == tbl_rd.echo_id && echo_seq_r == tbl_rd.echo_seq);
    end
  end

  always_comb begin
    tbl_wr.we_tcp   = (state_r == npt_pkg::ST_SCAN) && match && dir_out && is_tcp;
    tbl_wr.we_udp   = (state_r == npt_pkg::ST_SCAN) && match && dir_out && is_udp;
    tbl_wr.we_icmp  = (state_r == npt_pkg::ST_SCAN) && match && dir_out && is_icmp;
    tbl_wr.idx      = idx_r;
    tbl_wr.port     = src_port_r;
    tbl_wr.echo_id  = echo_id_r;
    tbl_wr.echo_seq = echo_seq_r;
  end

  always_comb begin
    csum_ctl.load = (state_r == npt_pkg::ST_SUM) &&
                    (step_r == npt_pkg::STEP_L4_SEG || step_r == npt_pkg::STEP_IP_REST);
    csum_ctl.add  = (state_r == npt_pkg::ST_SUM);
    case (step_r)
      npt_pkg::STEP_L4_SEG:    csum_ctl.term = l4_sum_r;
      npt_pkg::STEP_L4_SRC_HI: csum_ctl.term = nsrc_r[31:16];
      npt_pkg::STEP_L4_SRC_LO: csum_ctl.term = nsrc_r[15:0];
      npt_pkg::STEP_L4_DST_HI: csum_ctl.term = ndst_r[31:16];
      npt_pkg::STEP_L4_DST_LO: csum_ctl.term = ndst_r[15:0];
      npt_pkg::STEP_L4_PROTO:  csum_ctl.term = {8'd0, l4_proto};
      npt_pkg::STEP_L4_LEN:    csum_ctl.term = l4_length_r;
      npt_pkg::STEP_IP_REST:   csum_ctl.term = ip_rest_r;
      npt_pkg::STEP_IP_SRC_HI: csum_ctl.term = nsrc_r[31:16];
      npt_pkg::STEP_IP_SRC_LO: csum_ctl.term = nsrc_r[15:0];
      npt_pkg::STEP_IP_DST_HI: csum_ctl.term = ndst_r[31:16];
      npt_pkg::STEP_IP_DST_LO: csum_ctl.term = ndst_r[15:0];
      default:                 csum_ctl.term = 16'd0;
    endcase
  end

  npt_tables u_tables (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (tbl_wr),
    .rd_idx (idx_r),
    .rd     (tbl_rd)
  );

  npt_csum u_csum (
    .clk (clk),
    .ctl (csum_ctl),
    .sum (csum)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      npt_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_chan.on_wan_port &&
              (!in_chan.func || in_chan.dst_addr == public_addr_r)) begin
            state_nxt = npt_pkg::ST_SCAN;
          end else begin
            state_nxt = npt_pkg::ST_FIN;
          end
        end
      end
      npt_pkg::ST_SCAN: begin
        if (match) begin
          state_nxt = npt_pkg::ST_SUM;
        end else if (last) begin
          state_nxt = npt_pkg::ST_FIN;
        end
      end
      npt_pkg::ST_SUM: begin
        if (step_r == npt_pkg::STEP_IP_DST_LO) begin
          state_nxt = npt_pkg::ST_FIN;
        end
      end
      npt_pkg::ST_FIN: begin
        if (out_load) begin
          state_nxt = npt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = npt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= npt_pkg::ST_IDLE;
      out_valid_r     <= 1'b0;
      public_addr_r   <= npt_pkg::PUBLIC_ADDR_RST;
      inside_base_r   <= npt_pkg::INSIDE_BASE_RST;
      icmp_redirect_r <= npt_pkg::ICMP_REDIRECT_RST;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          npt_pkg::CFG_PUBLIC_ADDR:   public_addr_r   <= cfg_data;
          npt_pkg::CFG_INSIDE_BASE:   inside_base_r   <= cfg_data;
          npt_pkg::CFG_ICMP_REDIRECT: icmp_redirect_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r      <= in_chan.func;
      wan_r       <= in_chan.on_wan_port;
      protocol_r  <= in_chan.protocol;
      src_addr_r  <= in_chan.src_addr;
      src_port_r  <= in_chan.src_port;
      dst_port_r  <= in_chan.dst_port;
      echo_id_r   <= in_chan.echo_id;
      echo_seq_r  <= in_chan.echo_seq;
      l4_length_r <= in_chan.l4_length;
      l4_sum_r    <= in_chan.l4_sum;
      ip_rest_r   <= in_chan.ip_rest_sum;
      idx_r       <= '0;
      cand_r      <= inside_base_r + 32'd1;
      nsrc_r      <= in_chan.src_addr;
      ndst_r      <= in_chan.dst_addr;
      hit_r       <= 1'b0;
    end
    if (state_r == npt_pkg::ST_SCAN) begin
      if (match) begin
        hit_r  <= 1'b1;
        step_r <= is_icmp ? npt_pkg::STEP_IP_REST : npt_pkg::STEP_L4_SEG;
        if (dir_out) begin
          nsrc_r <= public_addr_r;
          if (is_icmp) begin
            ndst_r <= icmp_redirect_r;
          end
        end else begin
          ndst_r <= cand_r;
        end
      end else begin
        idx_r  <= idx_r + npt_pkg::IDX_W'(1);
        cand_r <= cand_r + 32'd1;
      end
    end
    if (state_r == npt_pkg::ST_SUM) begin
      step_r <= step_r + npt_pkg::STEP_W'(1);
      if (step_r == npt_pkg::STEP_IP_REST) begin
        l4_acc_r <= csum;
      end
    end
    if (out_load) begin
      rewritten_r <= hit_r;
      entry_r     <= hit_r ? 4'(idx_r) : 4'd0;
      out_src_r   <= nsrc_r;
      out_dst_r   <= ndst_r;
      ipc_r       <= hit_r ? ~csum : 16'd0;
      l4v_r       <= hit_r && !is_icmp;
      l4c_r       <= (hit_r && !is_icmp) ?
                     ((l4_acc_r == 16'hFFFF) ? 16'hFFFF : ~l4_acc_r) : 16'd0;
      reroute_r   <= hit_r && dir_out && is_icmp;
    end
  end

  assign in_chan.ready              = state_r == npt_pkg::ST_IDLE;
  assign out_chan.valid             = out_valid_r;
  assign out_chan.rewritten         = rewritten_r;
  assign out_chan.entry_index       = entry_r;
  assign out_chan.new_src_addr      = out_src_r;
  assign out_chan.new_dst_addr      = out_dst_r;
  assign out_chan.ip_checksum       = ipc_r;
  assign out_chan.l4_checksum       = l4c_r;
  assign out_chan.l4_checksum_valid = l4v_r;
  assign out_chan.reroute           = reroute_r;

endmodule
`default_nettype wire
